// ===== rtl/pfe_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the postfix evaluator.
package pfe_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam int ANSWER_WIDTH = 32;
   localparam int STATUS_WIDTH = 3;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_MISSING_OPD = 3'd1,
      STATUS_STACK_FULL  = 3'd2,
      STATUS_DIV_ZERO    = 3'd3,
      STATUS_EMPTY_END   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;       // capture the accepted item
      logic push_digit;
      logic pop;
      logic cap_right;
      logic cap_left;
      logic push_alu;    // push left +/- right
      logic start_unit;  // kick the iterative multiply/divide unit
      logic push_unit;
      logic rd_top;
      logic load_out;    // load the result register and clear for next expression
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_digit;
      logic is_op;
      logic is_muldiv;
      logic last;
      logic out_free;
      logic unit_busy;
   } stat_type;

endpackage

// ===== rtl/pfe_muldiv.sv =====
// Iterative multiply/divide unit: one multiplier bit or one quotient bit per cycle.
module pfe_muldiv #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   is_div,
   input  logic [VALUE_WIDTH-1:0] opd_a,
   input  logic [VALUE_WIDTH-1:0] opd_b,
   output logic                   busy,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int CW = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   div_ff, div_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] opa_ff, opa_in;
   logic [VALUE_WIDTH-1:0] opb_ff, opb_in;
   logic [VALUE_WIDTH:0]   rem_ff, rem_in;

   logic [VALUE_WIDTH-1:0] mag_a, mag_b;
   logic [VALUE_WIDTH:0]   rem_sh, diff;

   assign mag_a  = opd_a[VALUE_WIDTH-1] ? (~opd_a + 1'b1) : opd_a;
   assign mag_b  = opd_b[VALUE_WIDTH-1] ? (~opd_b + 1'b1) : opd_b;
   assign rem_sh = {rem_ff[VALUE_WIDTH-1:0], opa_ff[VALUE_WIDTH-1]};
   assign diff   = rem_sh - {1'b0, opb_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = is_div;
         neg_in  = opd_a[VALUE_WIDTH-1] ^ opd_b[VALUE_WIDTH-1];
         acc_in  = '0;
         rem_in  = '0;
         opa_in  = is_div ? mag_a : opd_a;
         opb_in  = is_div ? mag_b : opd_b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
         opa_in = {opa_ff[VALUE_WIDTH-2:0], 1'b0};
         if (div_ff) begin
            // restoring step: keep the difference when it did not go negative
            if (!diff[VALUE_WIDTH]) begin
               rem_in = diff;
            end else begin
               rem_in = rem_sh;
            end
            acc_in = {acc_ff[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
         end else begin
            if (opb_ff[0]) begin
               acc_in = acc_ff + opa_ff;
            end
            opb_in = {1'b0, opb_ff[VALUE_WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rem_ff <= rem_in;
   end

   assign busy   = busy_ff;
   assign result = (div_ff && neg_ff) ? (~acc_ff + 1'b1) : acc_ff;

endmodule

// ===== rtl/pfe_datapath.sv =====
// Datapath: input item register, value stack memory, operands, error tracking, result register.
module pfe_datapath #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pfe_pkg::cmd_type                      cmd,
   output pfe_pkg::stat_type                     stat,
   input  logic [7:0]                            char_code,
   input  logic                                  last_char,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pfe_pkg::ANSWER_WIDTH-1:0] rsp_answer,
   output logic [pfe_pkg::STATUS_WIDTH-1:0]      rsp_status
);

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CNTW = $clog2(STACK_DEPTH + 1);

   logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];

   logic [7:0]             char_ff;
   logic                   last_ff;
   logic [CNTW-1:0]        count_ff, count_in;
   logic [2:0]             err_ff, err_in;
   logic                   pop_zero_ff;
   logic                   div0_ff;
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [VALUE_WIDTH-1:0] right_ff, left_ff;
   pfe_pkg::op_type        op;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [pfe_pkg::ANSWER_WIDTH-1:0] answer_ff;
   logic [pfe_pkg::STATUS_WIDTH-1:0] status_ff;

   logic                   is_digit, is_op;
   logic                   empty, full;
   logic                   push_req, wr_en, rd_en;
   logic [VALUE_WIDTH-1:0] push_val, alu_val, unit_val, digit_val;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [2:0]             note_code;
   logic                   unit_busy;
   logic [63:0]            top_ext;
   logic                   out_free;

   assign is_digit  = (char_ff >= pfe_pkg::CHAR_ZERO) && (char_ff <= pfe_pkg::CHAR_NINE);
   assign is_op     = (char_ff == pfe_pkg::CHAR_PLUS) || (char_ff == pfe_pkg::CHAR_MINUS) ||
                      (char_ff == pfe_pkg::CHAR_STAR) || (char_ff == pfe_pkg::CHAR_SLASH);
   always_comb begin
      priority if (char_ff == pfe_pkg::CHAR_PLUS)  op = pfe_pkg::OP_ADD;
      else if     (char_ff == pfe_pkg::CHAR_MINUS) op = pfe_pkg::OP_SUB;
      else if     (char_ff == pfe_pkg::CHAR_STAR)  op = pfe_pkg::OP_MUL;
      else                                         op = pfe_pkg::OP_DIV;
   end

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNTW'(STACK_DEPTH));
   assign digit_val = VALUE_WIDTH'(char_ff[3:0]);
   assign alu_val   = (op == pfe_pkg::OP_SUB) ? (left_ff - right_ff) : (left_ff + right_ff);
   assign push_req  = cmd.push_digit | cmd.push_alu | cmd.push_unit;
   assign wr_en     = push_req && !full;
   assign wr_addr   = count_ff[AW-1:0];
   assign rd_addr   = AW'(count_ff - 1'b1);
   assign rd_en     = (cmd.pop && !empty) || cmd.rd_top;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      push_val = digit_val;
      if (cmd.push_alu) begin
         push_val = alu_val;
      end else if (cmd.push_unit) begin
         push_val = div0_ff ? '0 : unit_val;
      end
   end

   // stack count and first error
   always_comb begin
      count_in  = count_ff;
      note_code = pfe_pkg::STATUS_OK;
      if (cmd.pop) begin
         if (empty) begin
            note_code = pfe_pkg::STATUS_MISSING_OPD;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
      if (push_req) begin
         if (full) begin
            note_code = pfe_pkg::STATUS_STACK_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.start_unit && op == pfe_pkg::OP_DIV && right_ff == '0) begin
         note_code = pfe_pkg::STATUS_DIV_ZERO;
      end
      err_in = (err_ff == pfe_pkg::STATUS_OK) ? note_code : err_ff;
      if (cmd.load_out) begin
         count_in = '0;
         err_in   = pfe_pkg::STATUS_OK;
      end
   end

   assign top_ext = 64'(rd_data_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pfe_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= push_val;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff <= char_code;
         last_ff <= last_char;
      end
      if (cmd.pop) begin
         pop_zero_ff <= empty;
      end
      if (cmd.cap_right) begin
         right_ff <= pop_zero_ff ? '0 : rd_data_ff;
      end
      if (cmd.cap_left) begin
         left_ff <= pop_zero_ff ? '0 : rd_data_ff;
      end
      if (cmd.start_unit) begin
         div0_ff <= (op == pfe_pkg::OP_DIV) && (right_ff == '0);
      end
      if (cmd.load_out) begin
         answer_ff <= empty ? '0 : top_ext[pfe_pkg::ANSWER_WIDTH-1:0];
         if (err_ff != pfe_pkg::STATUS_OK) begin
            status_ff <= err_ff;
         end else if (empty) begin
            status_ff <= pfe_pkg::STATUS_EMPTY_END;
         end else begin
            status_ff <= pfe_pkg::STATUS_OK;
         end
      end
   end

   pfe_muldiv #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_unit),
      .is_div (op == pfe_pkg::OP_DIV),
      .opd_a  (left_ff),
      .opd_b  (right_ff),
      .busy   (unit_busy),
      .result (unit_val)
   );

   assign stat.is_digit  = is_digit;
   assign stat.is_op     = is_op;
   assign stat.is_muldiv = (op == pfe_pkg::OP_MUL) || (op == pfe_pkg::OP_DIV);
   assign stat.last      = last_ff;
   assign stat.out_free  = out_free;
   assign stat.unit_busy = unit_busy;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = answer_ff;
   assign rsp_status = status_ff;

endmodule

// ===== rtl/pfe_control.sv =====
// Controller state machine sequencing stack accesses and arithmetic for each item.
module pfe_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pfe_pkg::stat_type stat,
   output pfe_pkg::cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_DECODE   = 10'b00_0000_0010,
      ST_POP_R    = 10'b00_0000_0100,
      ST_POP_L    = 10'b00_0000_1000,
      ST_LOAD_L   = 10'b00_0001_0000,
      ST_EXEC     = 10'b00_0010_0000,
      ST_ITER     = 10'b00_0100_0000,
      ST_PUSH_RES = 10'b00_1000_0000,
      ST_FINISH   = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_digit) begin
               cmd.push_digit = 1'b1;
               state_in       = ST_FINISH;
            end else if (stat.is_op) begin
               state_in = ST_POP_R;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_POP_R: begin
            cmd.pop  = 1'b1;
            state_in = ST_POP_L;
         end
         ST_POP_L: begin
            cmd.cap_right = 1'b1;
            cmd.pop       = 1'b1;
            state_in      = ST_LOAD_L;
         end
         ST_LOAD_L: begin
            cmd.cap_left = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.is_muldiv) begin
               cmd.start_unit = 1'b1;
               state_in       = ST_ITER;
            end else begin
               cmd.push_alu = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_ITER: begin
            if (!stat.unit_busy) begin
               state_in = ST_PUSH_RES;
            end
         end
         ST_PUSH_RES: begin
            cmd.push_unit = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.last) begin
               cmd.rd_top = 1'b1;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator top level: controller plus stack datapath.
// Per item: a digit or ignored character passes idle, decode and finish; + or - also pops right
// and left, loads and executes; * or / then waits on the one-bit-per-cycle multiply/divide unit.
// A last-flagged item then reads the top and its result appears in the output register as the input
// opens again; while an earlier result is still stalled the item waits there.
// Synchronous active-high reset empties the stack, clears the error and drops any pending result.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_char_code,
   input  logic                                    req_last_char,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pfe_pkg::ANSWER_WIDTH-1:0] rsp_answer,
   output logic [pfe_pkg::STATUS_WIDTH-1:0]        rsp_status
);

   pfe_pkg::cmd_type  cmd;
   pfe_pkg::stat_type stat;

   pfe_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfe_datapath #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .char_code  (req_char_code),
      .last_char  (req_last_char),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status)
   );

endmodule
